FILE: rtl/core/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
package jsu_pkg;

  // Parser phases of the front end.
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_STR     = 4'd1,
    PH_ESC     = 4'd2,
    PH_HEX1    = 4'd3,
    PH_PAIR_BS = 4'd4,
    PH_PAIR_U  = 4'd5,
    PH_HEX2    = 4'd6
  } phase_e;

  // Kinds of result item.
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  // Segments of one request, emitted in this order.
  localparam int NumSeg = 5;
  localparam logic [2:0] SEG_A = 3'd0;  // first UTF-8 code point
  localparam logic [2:0] SEG_D = 3'd1;  // replayed hex digits
  localparam logic [2:0] SEG_B = 3'd2;  // second UTF-8 code point
  localparam logic [2:0] SEG_C = 3'd3;  // single content byte
  localparam logic [2:0] SEG_T = 3'd4;  // terminal status

  localparam int DigitDepth = 3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [15:0] HI_SUR_LO = 16'hD800;
  localparam logic [15:0] HI_SUR_HI = 16'hDBFF;
  localparam logic [15:0] LO_SUR_LO = 16'hDC00;
  localparam logic [15:0] LO_SUR_HI = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // One request: everything a single source byte asks the back end to emit.
  typedef struct packed {
    logic                       a_en;
    logic [20:0]                a_code;
    logic [1:0]                 d_cnt;
    logic [DigitDepth-1:0][7:0] d_bytes;
    logic                       b_en;
    logic [15:0]                b_code;
    logic                       c_en;
    logic [7:0]                 c_byte;
    logic                       t_en;
    kind_e                      t_kind;
  } cmd_t;

endpackage

FILE: rtl/core/jsu_front.sv
// Front end: parses source bytes and turns each into an emit request.
module jsu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       in_byte_i,
  input  logic             first_of_source_i,
  input  logic             last_of_source_i,
  output logic             push_o,
  output jsu_pkg::cmd_t    cmd_o
);

  jsu_pkg::phase_e phase_q, phase_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [15:0]     acc_q, acc_d;
  logic [15:0]     held_q, held_d;
  logic [jsu_pkg::DigitDepth-1:0][7:0] la_q, la_d;

  // Returns {is_digit, value}.
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  logic [4:0]  hv;
  logic [15:0] acc_new;
  logic        do_plain, do_esc;
  jsu_pkg::cmd_t cmd;

  assign hv      = hex_val(in_byte_i);
  assign acc_new = {acc_q[11:0], hv[3:0]};

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    held_d   = held_q;
    la_d     = la_q;
    cmd      = '0;
    do_plain = 1'b0;
    do_esc   = 1'b0;

    if (first_of_source_i) begin
      cnt_d  = 2'd0;
      acc_d  = 16'd0;
      held_d = 16'd0;
      if (in_byte_i == jsu_pkg::CH_QUOTE) begin
        phase_d = jsu_pkg::PH_STR;
      end else begin
        cmd.t_en   = 1'b1;
        cmd.t_kind = jsu_pkg::KIND_FAIL;
        phase_d    = jsu_pkg::PH_IDLE;
      end
    end else begin
      unique case (phase_q)
        jsu_pkg::PH_IDLE: begin
        end
        jsu_pkg::PH_STR: begin
          do_plain = 1'b1;
        end
        jsu_pkg::PH_ESC: begin
          do_esc = 1'b1;
        end
        jsu_pkg::PH_HEX1: begin
          if (!hv[4]) begin
            cmd.d_cnt = cnt_q;
            cnt_d     = 2'd0;
            do_plain  = 1'b1;
          end else begin
            acc_d = acc_new;
            if (cnt_q < 2'd3) begin
              la_d[cnt_q] = in_byte_i;
              cnt_d       = cnt_q + 2'd1;
            end else begin
              cnt_d = 2'd0;
              if (acc_new >= jsu_pkg::HI_SUR_LO && acc_new <= jsu_pkg::HI_SUR_HI) begin
                held_d  = acc_new;
                phase_d = jsu_pkg::PH_PAIR_BS;
              end else begin
                cmd.a_en   = 1'b1;
                cmd.a_code = {5'd0, acc_new};
                phase_d    = jsu_pkg::PH_STR;
              end
            end
          end
        end
        jsu_pkg::PH_PAIR_BS: begin
          if (in_byte_i == jsu_pkg::CH_BSLASH) begin
            phase_d = jsu_pkg::PH_PAIR_U;
          end else begin
            cmd.a_en   = 1'b1;
            cmd.a_code = {5'd0, held_q};
            do_plain   = 1'b1;
          end
        end
        jsu_pkg::PH_PAIR_U: begin
          if (in_byte_i == jsu_pkg::CH_U) begin
            phase_d = jsu_pkg::PH_HEX2;
            cnt_d   = 2'd0;
            acc_d   = 16'd0;
          end else begin
            cmd.a_en   = 1'b1;
            cmd.a_code = {5'd0, held_q};
            do_esc     = 1'b1;
          end
        end
        jsu_pkg::PH_HEX2: begin
          if (!hv[4]) begin
            cmd.a_en   = 1'b1;
            cmd.a_code = {5'd0, held_q};
            cmd.d_cnt  = cnt_q;
            cnt_d      = 2'd0;
            do_plain   = 1'b1;
          end else begin
            acc_d = acc_new;
            if (cnt_q < 2'd3) begin
              la_d[cnt_q] = in_byte_i;
              cnt_d       = cnt_q + 2'd1;
            end else begin
              cnt_d    = 2'd0;
              cmd.a_en = 1'b1;
              if (acc_new >= jsu_pkg::LO_SUR_LO && acc_new <= jsu_pkg::LO_SUR_HI) begin
                // Join the pair into one supplementary code point.
                cmd.a_code = jsu_pkg::SUPP_BASE + {1'b0, held_q[9:0], acc_new[9:0]};
                phase_d    = jsu_pkg::PH_STR;
              end else begin
                cmd.a_code = {5'd0, held_q};
                if (acc_new >= jsu_pkg::HI_SUR_LO && acc_new <= jsu_pkg::HI_SUR_HI) begin
                  held_d  = acc_new;
                  phase_d = jsu_pkg::PH_PAIR_BS;
                end else begin
                  cmd.b_en   = 1'b1;
                  cmd.b_code = acc_new;
                  phase_d    = jsu_pkg::PH_STR;
                end
              end
            end
          end
        end
        default: begin
          phase_d = jsu_pkg::PH_IDLE;
          cnt_d   = 2'd0;
        end
      endcase
    end

    if (do_esc) begin
      phase_d = jsu_pkg::PH_STR;
      unique case (in_byte_i)
        jsu_pkg::CH_N: begin
          cmd.c_en   = 1'b1;
          cmd.c_byte = jsu_pkg::CH_LF;
        end
        jsu_pkg::CH_R: begin
          cmd.c_en   = 1'b1;
          cmd.c_byte = jsu_pkg::CH_CR;
        end
        jsu_pkg::CH_T: begin
          cmd.c_en   = 1'b1;
          cmd.c_byte = jsu_pkg::CH_TAB;
        end
        jsu_pkg::CH_U: begin
          phase_d = jsu_pkg::PH_HEX1;
          cnt_d   = 2'd0;
          acc_d   = 16'd0;
        end
        default: begin
          cmd.c_en   = 1'b1;
          cmd.c_byte = in_byte_i;
        end
      endcase
    end

    if (do_plain) begin
      if (in_byte_i == jsu_pkg::CH_QUOTE) begin
        cmd.t_en   = 1'b1;
        cmd.t_kind = jsu_pkg::KIND_OK;
        phase_d    = jsu_pkg::PH_IDLE;
        cnt_d      = 2'd0;
      end else if (in_byte_i == jsu_pkg::CH_BSLASH) begin
        phase_d = jsu_pkg::PH_ESC;
      end else begin
        cmd.c_en   = 1'b1;
        cmd.c_byte = in_byte_i;
        phase_d    = jsu_pkg::PH_STR;
      end
    end

    // End of source while a string is still open: flush what is pending, then fail.
    if (last_of_source_i && phase_d != jsu_pkg::PH_IDLE) begin
      unique case (phase_d)
        jsu_pkg::PH_ESC: begin
          cmd.c_en   = 1'b1;
          cmd.c_byte = jsu_pkg::CH_BSLASH;
        end
        jsu_pkg::PH_HEX1: begin
          cmd.d_cnt = cnt_d;
        end
        jsu_pkg::PH_PAIR_BS: begin
          cmd.b_en   = 1'b1;
          cmd.b_code = held_d;
        end
        jsu_pkg::PH_PAIR_U: begin
          cmd.b_en   = 1'b1;
          cmd.b_code = held_d;
          cmd.c_en   = 1'b1;
          cmd.c_byte = jsu_pkg::CH_BSLASH;
        end
        jsu_pkg::PH_HEX2: begin
          cmd.a_en   = 1'b1;
          cmd.a_code = {5'd0, held_d};
          cmd.d_cnt  = cnt_d;
        end
        default: begin
        end
      endcase
      cmd.t_en   = 1'b1;
      cmd.t_kind = jsu_pkg::KIND_FAIL;
      phase_d    = jsu_pkg::PH_IDLE;
      cnt_d      = 2'd0;
    end

    cmd.d_bytes = la_d;
  end

  assign cmd_o  = cmd;
  assign push_o = accept_i &&
                  (cmd.a_en || (cmd.d_cnt != 2'd0) || cmd.b_en || cmd.c_en || cmd.t_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jsu_pkg::PH_IDLE;
      cnt_q   <= 2'd0;
      acc_q   <= 16'd0;
      held_q  <= 16'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      la_q <= la_d;
    end
  end

endmodule

FILE: rtl/core/jsu_cmdq.sv
// Short request queue between the parser front end and the emit back end.
module jsu_cmdq #(
  parameter int Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          nonempty_o,
  output jsu_pkg::cmd_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  jsu_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            wr_en, rd_en;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];
  assign wr_en      = push_i && !full_o;
  assign rd_en      = pop_i && nonempty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (rd_en) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/jsu_back.sv
// Back end: walks the segments of each request and emits one result per cycle unless stalled.
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          nonempty_i,
  input  jsu_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [1:0]    out_kind_o,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o
);

  function automatic logic [2:0] utf8_len(input logic [20:0] code);
    logic [2:0] l;
    if (code < 21'h80) begin
      l = 3'd1;
    end else if (code < 21'h800) begin
      l = 3'd2;
    end else if (code < 21'h10000) begin
      l = 3'd3;
    end else begin
      l = 3'd4;
    end
    return l;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] code, input logic [2:0] len,
                                           input logic [1:0] k);
    logic [7:0] r;
    r = {2'b10, code[5:0]};
    case (len)
      3'd1: r = {1'b0, code[6:0]};
      3'd2: begin
        if (k == 2'd0) r = {3'b110, code[10:6]};
      end
      3'd3: begin
        if (k == 2'd0) r = {4'b1110, code[15:12]};
        else if (k == 2'd1) r = {2'b10, code[11:6]};
      end
      default: begin
        if (k == 2'd0) r = {5'b11110, code[20:18]};
        else if (k == 2'd1) r = {2'b10, code[17:12]};
        else if (k == 2'd2) r = {2'b10, code[11:6]};
      end
    endcase
    return r;
  endfunction

  logic [2:0] seg_q, seg_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q;
  logic [1:0] out_kind_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic [jsu_pkg::NumSeg-1:0] pres;
  logic [2:0] len [jsu_pkg::NumSeg];
  logic [2:0] cur, cur_len;
  logic       found, more, seg_end, adv;
  logic [1:0] kind;
  logic [7:0] bval;
  logic [2:0] len_a, len_b;

  assign len_a = utf8_len(head_i.a_code);
  assign len_b = utf8_len({5'd0, head_i.b_code});

  always_comb begin
    pres[jsu_pkg::SEG_A] = head_i.a_en;
    pres[jsu_pkg::SEG_D] = (head_i.d_cnt != 2'd0);
    pres[jsu_pkg::SEG_B] = head_i.b_en;
    pres[jsu_pkg::SEG_C] = head_i.c_en;
    pres[jsu_pkg::SEG_T] = head_i.t_en;
    len[jsu_pkg::SEG_A]  = len_a;
    len[jsu_pkg::SEG_D]  = {1'b0, head_i.d_cnt};
    len[jsu_pkg::SEG_B]  = len_b;
    len[jsu_pkg::SEG_C]  = 3'd1;
    len[jsu_pkg::SEG_T]  = 3'd1;
  end

  // Current segment is the first present one at or after the segment pointer.
  always_comb begin
    cur   = jsu_pkg::SEG_T;
    found = 1'b0;
    more  = 1'b0;
    for (int s = 0; s < jsu_pkg::NumSeg; s++) begin
      if (!found && pres[s] && (3'(s) >= seg_q)) begin
        cur   = 3'(s);
        found = 1'b1;
      end else if (found && pres[s]) begin
        more = 1'b1;
      end
    end
  end

  assign cur_len = len[cur];
  assign seg_end = ({1'b0, idx_q} == (cur_len - 3'd1));
  assign adv     = nonempty_i && (!out_valid_q || !out_stall_i);
  assign pop_o   = adv && seg_end && !more;

  always_comb begin
    kind = jsu_pkg::KIND_BYTE;
    bval = 8'd0;
    case (cur)
      jsu_pkg::SEG_A: bval = utf8_byte(head_i.a_code, len_a, idx_q);
      jsu_pkg::SEG_D: bval = head_i.d_bytes[idx_q];
      jsu_pkg::SEG_B: bval = utf8_byte({5'd0, head_i.b_code}, len_b, idx_q);
      jsu_pkg::SEG_C: bval = head_i.c_byte;
      default:        kind = head_i.t_kind;
    endcase
  end

  always_comb begin
    seg_d = seg_q;
    idx_d = idx_q;
    if (adv) begin
      if (pop_o) begin
        seg_d = jsu_pkg::SEG_A;
        idx_d = 2'd0;
      end else if (seg_end) begin
        seg_d = cur + 3'd1;
        idx_d = 2'd0;
      end else begin
        seg_d = cur;
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= jsu_pkg::SEG_A;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      seg_q <= seg_d;
      idx_q <= idx_d;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_kind_q <= kind;
      out_byte_q <= bval;
      out_last_q <= seg_end && !more;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: rtl/core/json_string_unescape_utf8_top.sv
// Top level of the JSON string unescaper with UTF-8 output.
// A byte's first result passes the request queue and then the output register of the back end.
// One source byte per cycle when not stalled; a byte's results then each hold the emit stage.
// The parser stalls the source only when the request queue between the two halves is full.
// Reset: rst_ni is asynchronous, active low; it empties the queue and idles the parser.
module json_string_unescape_utf8_top #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       first_of_source_i,
  input  logic       last_of_source_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  // The front end decides, per source byte, the whole request: up to two code points
  // to encode, replayed hex digits, one content byte and a closing status.
  logic          accept;
  logic          push, full, pop, nonempty;
  jsu_pkg::cmd_t cmd, head;

  // A request is accepted whenever the queue has room, so plain text flows at one
  // byte per cycle until the queue fills while the back end drains multi-byte escapes.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  jsu_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .in_byte_i         (in_byte_i),
    .first_of_source_i (first_of_source_i),
    .last_of_source_i  (last_of_source_i),
    .push_o            (push),
    .cmd_o             (cmd)
  );

  // Bytes that cause no result (idle bytes, gathered hex digits) push nothing.
  jsu_cmdq #(
    .Depth (QueueDepth)
  ) u_cmdq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd),
    .full_o      (full),
    .pop_i       (pop),
    .nonempty_o  (nonempty),
    .head_o      (head)
  );

  // The back end emits one result per cycle, unless its output is stalled, into its output
  // register and retires the request with its last result.
  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nonempty_i  (nonempty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

FILE: rtl/core/jsu_checker.sv
// Port-level checks of the JSON string unescaper, bound to its top level.
module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] out_kind_o,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(out_kind_o) && $stable(out_last_o))
    else $error("stalled result changed");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o != jsu_pkg::KIND_BYTE) |-> out_last_o)
    else $error("status result not last of its request");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o != jsu_pkg::KIND_BYTE) |-> (out_byte_o == 8'd0))
    else $error("status result carries a byte");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_kind_o == jsu_pkg::KIND_BYTE) || (out_kind_o == jsu_pkg::KIND_OK) ||
    (out_kind_o == jsu_pkg::KIND_FAIL))
    else $error("unknown result kind");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_kind_o  (out_kind_o),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);

FILE: verif/tb_json_string_unescape_utf8_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
module tb_json_string_unescape_utf8_top;

  localparam int MaxResults  = 8;
  localparam int MaxGap      = 18;
  localparam int SourceBytes = 400;
  localparam int LongHold    = 300;
  localparam int CycleLimit  = 500000;
  localparam int ShownErrors = 10;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;

  // One output item of the block, as the scoreboard expects it.
  typedef struct packed {
    jsu_pkg::kind_e kind;
    logic [7:0]     data;
    logic           last;
  } utf8_out_t;

  // One source byte together with its framing flags.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } src_byte_t;

  // The scoreboard keeps its own copy of the parser state. For every source byte the
  // block accepts it works out the UTF-8 bytes and status items that byte must cause
  // and queues them; every result the block delivers is matched against the oldest one.
  class unescape_scoreboard;
    jsu_pkg::phase_e phase;
    logic [7:0]      digit_buf [jsu_pkg::DigitDepth];
    int unsigned     digit_cnt;
    logic [15:0]     hex_acc;
    logic [15:0]     held_hi;
    utf8_out_t       step_q[$];
    utf8_out_t       utf8_expected_q[$];
    int unsigned     mismatches;
    int unsigned     checked;

    function new();
      phase      = jsu_pkg::PH_IDLE;
      digit_cnt  = 0;
      hex_acc    = '0;
      held_hi    = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function int unsigned pending();
      return utf8_expected_q.size();
    endfunction

    // A single source byte never causes more than eight results.
    function void put(jsu_pkg::kind_e kind, logic [7:0] data);
      utf8_out_t item;
      item.kind = kind;
      item.data = data;
      item.last = 1'b0;
      if (step_q.size() < MaxResults) step_q.insert(step_q.size(), item);
    endfunction

    function void close_string();
      phase     = jsu_pkg::PH_IDLE;
      digit_cnt = 0;
    endfunction

    function void emit_code(logic [20:0] cp);
      if (cp < 21'h80) begin
        put(jsu_pkg::KIND_BYTE, cp[7:0]);
      end else if (cp < 21'h800) begin
        put(jsu_pkg::KIND_BYTE, {3'b110, cp[10:6]});
        put(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]});
      end else if (cp < jsu_pkg::SUPP_BASE) begin
        put(jsu_pkg::KIND_BYTE, {4'b1110, cp[15:12]});
        put(jsu_pkg::KIND_BYTE, {2'b10, cp[11:6]});
        put(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]});
      end else begin
        put(jsu_pkg::KIND_BYTE, {5'b11110, cp[20:18]});
        put(jsu_pkg::KIND_BYTE, {2'b10, cp[17:12]});
        put(jsu_pkg::KIND_BYTE, {2'b10, cp[11:6]});
        put(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]});
      end
    endfunction

    function int hex_val(logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
      if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
      if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
      return -1;
    endfunction

    // Hex digits gathered so far are replayed as plain text.
    function void flush_digits();
      for (int k = 0; k < digit_cnt; k++) put(jsu_pkg::KIND_BYTE, digit_buf[k]);
      digit_cnt = 0;
    endfunction

    function void plain_byte(logic [7:0] b);
      if (b == jsu_pkg::CH_QUOTE) begin
        put(jsu_pkg::KIND_OK, 8'h00);
        close_string();
      end else if (b == jsu_pkg::CH_BSLASH) begin
        phase = jsu_pkg::PH_ESC;
      end else begin
        put(jsu_pkg::KIND_BYTE, b);
        phase = jsu_pkg::PH_STR;
      end
    endfunction

    function void escape_byte(logic [7:0] b);
      phase = jsu_pkg::PH_STR;
      case (b)
        jsu_pkg::CH_N: put(jsu_pkg::KIND_BYTE, jsu_pkg::CH_LF);
        jsu_pkg::CH_R: put(jsu_pkg::KIND_BYTE, jsu_pkg::CH_CR);
        jsu_pkg::CH_T: put(jsu_pkg::KIND_BYTE, jsu_pkg::CH_TAB);
        jsu_pkg::CH_U: begin
          phase     = jsu_pkg::PH_HEX1;
          digit_cnt = 0;
          hex_acc   = '0;
        end
        default: put(jsu_pkg::KIND_BYTE, b);
      endcase
    endfunction

    // A high surrogate is held back in case a low one follows.
    function void finish_code(logic [15:0] code);
      if (code >= jsu_pkg::HI_SUR_LO && code <= jsu_pkg::HI_SUR_HI) begin
        held_hi = code;
        phase   = jsu_pkg::PH_PAIR_BS;
      end else begin
        emit_code({5'd0, code});
        phase = jsu_pkg::PH_STR;
      end
    endfunction

    // Returns 1 once the fourth digit is in.
    function bit take_digit(int d, logic [7:0] b);
      hex_acc = {hex_acc[11:0], 4'(d)};
      if (digit_cnt < jsu_pkg::DigitDepth) begin
        digit_buf[digit_cnt] = b;
        digit_cnt++;
        return 1'b0;
      end
      digit_cnt = 0;
      return 1'b1;
    endfunction

    function void feed(logic [7:0] b);
      int          d;
      logic [15:0] low;
      logic [20:0] cp;
      d = hex_val(b);
      case (phase)
        jsu_pkg::PH_STR: plain_byte(b);
        jsu_pkg::PH_ESC: escape_byte(b);
        jsu_pkg::PH_HEX1: begin
          if (d < 0) begin
            flush_digits();
            plain_byte(b);
          end else if (take_digit(d, b)) begin
            finish_code(hex_acc);
          end
        end
        jsu_pkg::PH_PAIR_BS: begin
          if (b == jsu_pkg::CH_BSLASH) begin
            phase = jsu_pkg::PH_PAIR_U;
          end else begin
            emit_code({5'd0, held_hi});
            plain_byte(b);
          end
        end
        jsu_pkg::PH_PAIR_U: begin
          if (b == jsu_pkg::CH_U) begin
            phase     = jsu_pkg::PH_HEX2;
            digit_cnt = 0;
            hex_acc   = '0;
          end else begin
            emit_code({5'd0, held_hi});
            escape_byte(b);
          end
        end
        jsu_pkg::PH_HEX2: begin
          if (d < 0) begin
            emit_code({5'd0, held_hi});
            flush_digits();
            plain_byte(b);
          end else if (take_digit(d, b)) begin
            low = hex_acc;
            if (low >= jsu_pkg::LO_SUR_LO && low <= jsu_pkg::LO_SUR_HI) begin
              cp = jsu_pkg::SUPP_BASE + ({5'd0, held_hi - jsu_pkg::HI_SUR_LO} << 10) +
                   {5'd0, low - jsu_pkg::LO_SUR_LO};
              emit_code(cp);
              phase = jsu_pkg::PH_STR;
            end else begin
              emit_code({5'd0, held_hi});
              finish_code(low);
            end
          end
        end
        default: close_string();
      endcase
    endfunction

    // Whatever is still pending goes out as text before the failure status.
    function void end_of_source();
      case (phase)
        jsu_pkg::PH_ESC:     put(jsu_pkg::KIND_BYTE, jsu_pkg::CH_BSLASH);
        jsu_pkg::PH_HEX1:    flush_digits();
        jsu_pkg::PH_PAIR_BS: emit_code({5'd0, held_hi});
        jsu_pkg::PH_PAIR_U: begin
          emit_code({5'd0, held_hi});
          put(jsu_pkg::KIND_BYTE, jsu_pkg::CH_BSLASH);
        end
        jsu_pkg::PH_HEX2: begin
          emit_code({5'd0, held_hi});
          flush_digits();
        end
        default: ;
      endcase
      put(jsu_pkg::KIND_FAIL, 8'h00);
      close_string();
    endfunction

    function void predict_utf8(logic [7:0] b, logic first, logic last);
      step_q.delete();
      if (first) begin
        digit_cnt = 0;
        hex_acc   = '0;
        held_hi   = '0;
        if (b == jsu_pkg::CH_QUOTE) begin
          phase = jsu_pkg::PH_STR;
        end else begin
          put(jsu_pkg::KIND_FAIL, 8'h00);
          close_string();
        end
      end else if (phase != jsu_pkg::PH_IDLE) begin
        feed(b);
      end
      if (last && phase != jsu_pkg::PH_IDLE) end_of_source();
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) utf8_expected_q.insert(utf8_expected_q.size(), step_q[i]);
    endfunction

    function void check_utf8(logic [1:0] kind, logic [7:0] data, logic last);
      utf8_out_t want;
      checked++;
      if (utf8_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ShownErrors)
          $display("Unexpected result kind %0d byte 0x%02h last %0b: nothing pending",
                   kind, data, last);
        return;
      end
      want = utf8_expected_q.pop_front();
      if (kind !== want.kind || data !== want.data || last !== want.last) begin
        mismatches++;
        if (mismatches <= ShownErrors)
          $display("Result %0d wrong: want kind %0d byte 0x%02h last %0b, got %0d 0x%02h %0b",
                   checked, want.kind, want.data, want.last, kind, data, last);
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni            = 1'b0;
  logic       in_valid_i        = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i         = 8'h00;
  logic       first_of_source_i = 1'b0;
  logic       last_of_source_i  = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i       = 1'b0;
  logic [1:0] out_kind_o;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  unescape_scoreboard board;
  src_byte_t          src_q[$];
  int                 noise_n    = 0;
  int                 accepted_n = 0;
  int                 cycle_n    = 0;

  json_string_unescape_utf8_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .first_of_source_i(first_of_source_i),
    .last_of_source_i (last_of_source_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_kind_o       (out_kind_o),
    .out_byte_o       (out_byte_o),
    .out_last_o       (out_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Stimulus construction. The whole byte stream is built up front as a queue of
  // source bytes with their first/last flags; the sender then plays it out.
  // ---------------------------------------------------------------------------

  function automatic void push_src(logic [7:0] data, logic first, logic last);
    src_byte_t item;
    item.data  = data;
    item.first = first;
    item.last  = last;
    src_q.insert(src_q.size(), item);
  endfunction

  function automatic void mark_last();
    src_q[src_q.size() - 1].last = 1'b1;
  endfunction

  // Letters come in either case, since the parser must take both.
  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic bit is_hex(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  // Pushes a backslash-u escape; fewer than four digits leaves it unfinished.
  function automatic void push_hex_escape(logic [15:0] code, int n_digits);
    push_src(jsu_pkg::CH_BSLASH, 1'b0, 1'b0);
    push_src(jsu_pkg::CH_U, 1'b0, 1'b0);
    for (int i = 0; i < n_digits; i++) push_src(hex_char(code[15 - 4 * i -: 4]), 1'b0, 1'b0);
  endfunction

  // Any content byte except the quote and the backslash, half of them printable.
  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 1) != 0) b = 8'($urandom_range(8'h20, 8'h7E));
      else b = 8'($urandom_range(0, 255));
    end while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
    return b;
  endfunction

  // A byte that breaks off a hex escape; now and then it is the closing quote.
  function automatic logic [7:0] rand_non_hex();
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0) return jsu_pkg::CH_QUOTE;
    do b = rand_plain(); while (is_hex(b));
    return b;
  endfunction

  // The byte after a backslash, never u.
  function automatic logic [7:0] rand_escaped();
    logic [7:0] named [8];
    logic [7:0] b;
    named = '{jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_T, CH_B, CH_F, jsu_pkg::CH_QUOTE,
              jsu_pkg::CH_BSLASH, CH_SLASH};
    if ($urandom_range(0, 9) < 7) return named[$urandom_range(0, 7)];
    do b = 8'($urandom_range(0, 255)); while (b == jsu_pkg::CH_U);
    return b;
  endfunction

  // A code point that is no surrogate, with the UTF-8 length boundaries favored.
  function automatic logic [15:0] rand_code();
    logic [15:0] corner [8];
    logic [15:0] code;
    corner = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF, 16'hE000,
               16'hFFFF};
    case ($urandom_range(0, 9))
      0:       code = corner[$urandom_range(0, 7)];
      1, 2:    code = 16'($urandom_range(16'h0000, 16'h007F));
      3, 4:    code = 16'($urandom_range(16'h0080, 16'h07FF));
      default: begin
        do code = 16'($urandom_range(16'h0800, 16'hFFFF));
        while (code >= jsu_pkg::HI_SUR_LO && code <= jsu_pkg::LO_SUR_HI);
      end
    endcase
    return code;
  endfunction

  function automatic logic [15:0] rand_high();
    if ($urandom_range(0, 3) == 0)
      return ($urandom_range(0, 1) != 0) ? jsu_pkg::HI_SUR_LO : jsu_pkg::HI_SUR_HI;
    return 16'($urandom_range(jsu_pkg::HI_SUR_LO, jsu_pkg::HI_SUR_HI));
  endfunction

  function automatic logic [15:0] rand_low();
    if ($urandom_range(0, 3) == 0)
      return ($urandom_range(0, 1) != 0) ? jsu_pkg::LO_SUR_LO : jsu_pkg::LO_SUR_HI;
    return 16'($urandom_range(jsu_pkg::LO_SUR_LO, jsu_pkg::LO_SUR_HI));
  endfunction

  // One piece of string content. Most are well formed; the rest exercise lone
  // surrogates, broken pairs and escapes cut short by a non-hex byte.
  function automatic void push_token();
    int          sel;
    logic [15:0] hi;
    sel = $urandom_range(0, 99);
    hi  = rand_high();
    if (sel < 35) begin
      repeat ($urandom_range(1, 3)) push_src(rand_plain(), 1'b0, 1'b0);
    end else if (sel < 50) begin
      push_src(jsu_pkg::CH_BSLASH, 1'b0, 1'b0);
      push_src(rand_escaped(), 1'b0, 1'b0);
    end else if (sel < 68) begin
      push_hex_escape(rand_code(), 4);
    end else if (sel < 78) begin
      push_hex_escape(hi, 4);
      push_hex_escape(rand_low(), 4);
    end else if (sel < 83) begin
      push_hex_escape(hi, 4);
    end else if (sel < 86) begin
      push_hex_escape(rand_low(), 4);
    end else if (sel < 89) begin
      // A high surrogate followed by an escape that is not a low one.
      push_hex_escape(hi, 4);
      push_hex_escape(($urandom_range(0, 2) == 0) ? rand_high() : rand_code(), 4);
    end else if (sel < 93) begin
      push_hex_escape(hi, 4);
      push_src(jsu_pkg::CH_BSLASH, 1'b0, 1'b0);
      push_src(rand_escaped(), 1'b0, 1'b0);
    end else if (sel < 97) begin
      push_hex_escape(rand_code(), $urandom_range(0, 3));
      push_src(rand_non_hex(), 1'b0, 1'b0);
    end else begin
      push_hex_escape(hi, 4);
      push_hex_escape(rand_low(), $urandom_range(0, 3));
      push_src(rand_non_hex(), 1'b0, 1'b0);
    end
  endfunction

  // A tail that leaves the parser in the middle of something.
  function automatic void push_open_end();
    case ($urandom_range(0, 5))
      0: push_src(rand_plain(), 1'b0, 1'b0);
      1: push_src(jsu_pkg::CH_BSLASH, 1'b0, 1'b0);
      2: push_hex_escape(rand_code(), $urandom_range(0, 3));
      3: push_hex_escape(rand_high(), 4);
      4: begin
        push_hex_escape(rand_high(), 4);
        push_src(jsu_pkg::CH_BSLASH, 1'b0, 1'b0);
      end
      default: begin
        push_hex_escape(rand_high(), 4);
        push_hex_escape(rand_low(), $urandom_range(0, 3));
      end
    endcase
  endfunction

  // One quoted string. It is closed normally, cut off by end of source while
  // something is pending, or abandoned so that the next string restarts the parser.
  function automatic void push_source();
    int ending;
    if ($urandom_range(0, 19) == 0) push_src(rand_plain(), 1'b1, 1'($urandom_range(0, 1)));
    push_src(jsu_pkg::CH_QUOTE, 1'b1, 1'b0);
    repeat ($urandom_range(0, 8)) push_token();
    ending = $urandom_range(0, 99);
    if (ending < 60) begin
      push_src(jsu_pkg::CH_QUOTE, 1'b0, 1'($urandom_range(0, 1)));
    end else if (ending < 80) begin
      push_open_end();
      mark_last();
    end else if (ending < 90) begin
      push_open_end();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake drivers. Inputs change on the falling edge; a request counts as
  // accepted at the rising edge where valid is high and stall is low.
  // ---------------------------------------------------------------------------

  task automatic send_byte(src_byte_t item, int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    in_byte_i         = item.data;
    first_of_source_i = item.first;
    last_of_source_i  = item.last;
    do @(posedge clk_i); while (in_stall_o);
    board.predict_utf8(item.data, item.first, item.last);
    accepted_n++;
  endtask

  // Receiver: stalls a random number of cycles before each result, with stretches
  // where it takes every result at once. Early in the run it holds off for a long
  // stretch so that the request queue fills and the block stalls the source.
  initial begin
    int unsigned seen;
    int          gap;
    bit          held_long;
    seen      = 0;
    held_long = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_long && seen == 40) begin
        out_stall_i = 1'b1;
        repeat (LongHold) @(negedge clk_i);
        held_long = 1'b1;
      end
      gap = (seen % 90 < 20) ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
        out_stall_i = 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      board.check_utf8(out_kind_o, out_byte_o, out_last_o);
      seen++;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_n++;
    if (cycle_n > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results pending", cycle_n, board.pending());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int directed_n;
    board = new();

    // Directed opening: a bad opening byte, a byte ignored while idle, a string
    // opened and ended by the same byte, extreme content bytes, a surrogate pair,
    // a dangling backslash at end of source, and a hex escape broken by a non-hex
    // byte that is then cut off by end of source.
    push_src(8'h78, 1'b1, 1'b0);
    push_src(8'hFF, 1'b0, 1'b0);
    push_src(jsu_pkg::CH_QUOTE, 1'b1, 1'b1);
    push_src(jsu_pkg::CH_QUOTE, 1'b1, 1'b0);
    push_src(8'h00, 1'b0, 1'b0);
    push_src(8'hFF, 1'b0, 1'b0);
    push_hex_escape(16'hD83D, 4);
    push_hex_escape(16'hDE00, 4);
    push_src(jsu_pkg::CH_QUOTE, 1'b0, 1'b0);
    push_src(jsu_pkg::CH_QUOTE, 1'b1, 1'b0);
    push_src(jsu_pkg::CH_BSLASH, 1'b0, 1'b1);
    push_src(jsu_pkg::CH_QUOTE, 1'b1, 1'b0);
    push_hex_escape(16'h004F, 2);
    push_src(8'h67, 1'b0, 1'b1);
    directed_n = src_q.size();

    // Random part: mostly well-formed strings, with a little noise between them.
    while (src_q.size() < SourceBytes) begin
      push_source();
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          push_src(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0),
                   1'($urandom_range(0, 7) == 0));
          noise_n++;
        end
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The sender goes back to back for a stretch of every 64 bytes. Halfway through
    // it parks until every outstanding result has been delivered.
    foreach (src_q[i]) begin
      if (i == src_q.size() / 2) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        while (board.pending() != 0) @(posedge clk_i);
      end
      send_byte(src_q[i], (i % 64 < 12) ? 0 : $urandom_range(0, MaxGap));
    end
    @(negedge clk_i);
    in_valid_i        = 1'b0;
    first_of_source_i = 1'b0;
    last_of_source_i  = 1'b0;

    // Drain, then give the block a few more cycles to show any stray result.
    while (board.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Streamed %0d source bytes (%0d directed, %0d noise) in %0d cycles.",
             accepted_n, directed_n, noise_n, cycle_n);
    $display("Checked %0d output items against the prediction, %0d wrong.",
             board.checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
